// File: src/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared widths, codes and types of the least-squares line fit block.
// ----------------------------------------------------------------------------
`default_nettype none

package lsf_pkg;

  // sample and accumulator widths
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_PAIRS   = 65536;
  localparam int CNT_W       = 17;
  localparam int AX_W        = 33;
  localparam int AXX_W       = 47;
  localparam int AXY_W       = 48;

  // serial multiplier: 64-bit multiplicand, 48-bit multiplier
  localparam int PROD_W      = 64;
  localparam int MUL_B_W     = 48;
  localparam int MUL_STEPS   = MUL_B_W;
  localparam int MUL_CNT_W   = 6;

  // restoring divider: 80-bit dividend, 64-bit divisor
  localparam int DVD_W       = 80;
  localparam int DIV_STEPS   = DVD_W;
  localparam int DIV_CNT_W   = 7;
  localparam int FRAC_BITS   = 16;
  localparam int OFS_SHIFT   = 8;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FLAT = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  typedef enum logic [2:0] {
    MOP_N_SXX,
    MOP_SX_SX,
    MOP_N_SXY,
    MOP_SX_SY,
    MOP_SX_SLOPE
  } mop_t;

  typedef enum logic {
    DOP_SLOPE,
    DOP_OFFSET
  } dop_t;

  typedef enum logic [1:0] {
    EM_FIT,
    EM_NONE,
    EM_FLAT
  } emit_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_G1,
    S_M1,
    S_G2,
    S_M2,
    S_CHK,
    S_M3,
    S_G4,
    S_M4,
    S_GD1,
    S_D1,
    S_G5,
    S_M5,
    S_GD2,
    S_D2,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic  mul_go;
    mop_t  mop;
    logic  div_go;
    dop_t  dop;
    logic  emit;
    emit_t kind;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic n_zero;
    logic den_nonpos;
  } sts_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? $unsigned(-v) : $unsigned(v);
  endfunction

endpackage

`default_nettype wire

// File: src/lsf_ctrl.sv
// ----------------------------------------------------------------------------
// lsf_ctrl
// Sequencer of the fit: runs the products and divisions in order.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic          last_pair,
  input  wire lsf_pkg::sts_t sts,
  output lsf_pkg::cmd_t      cmd,
  output logic               busy
);

  lsf_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.mop    = lsf_pkg::MOP_N_SXX;
    cmd.dop    = lsf_pkg::DOP_SLOPE;
    cmd.kind   = lsf_pkg::EM_FIT;
    case (state_r)
      lsf_pkg::S_IDLE: begin
        if (accept && last_pair) state_nxt = lsf_pkg::S_G1;
      end
      lsf_pkg::S_G1: begin
        cmd.mul_go = 1'b1;
        cmd.mop    = lsf_pkg::MOP_N_SXX;
        state_nxt  = lsf_pkg::S_M1;
      end
      lsf_pkg::S_M1: begin
        if (sts.mul_done) state_nxt = lsf_pkg::S_G2;
      end
      lsf_pkg::S_G2: begin
        cmd.mul_go = 1'b1;
        cmd.mop    = lsf_pkg::MOP_SX_SX;
        state_nxt  = lsf_pkg::S_M2;
      end
      lsf_pkg::S_M2: begin
        if (sts.mul_done) state_nxt = lsf_pkg::S_CHK;
      end
      // degenerate sets report at once
      lsf_pkg::S_CHK: begin
        if (sts.n_zero) begin
          cmd.emit  = 1'b1;
          cmd.kind  = lsf_pkg::EM_NONE;
          state_nxt = lsf_pkg::S_IDLE;
        end else if (sts.den_nonpos) begin
          cmd.emit  = 1'b1;
          cmd.kind  = lsf_pkg::EM_FLAT;
          state_nxt = lsf_pkg::S_IDLE;
        end else begin
          cmd.mul_go = 1'b1;
          cmd.mop    = lsf_pkg::MOP_N_SXY;
          state_nxt  = lsf_pkg::S_M3;
        end
      end
      lsf_pkg::S_M3: begin
        if (sts.mul_done) state_nxt = lsf_pkg::S_G4;
      end
      lsf_pkg::S_G4: begin
        cmd.mul_go = 1'b1;
        cmd.mop    = lsf_pkg::MOP_SX_SY;
        state_nxt  = lsf_pkg::S_M4;
      end
      lsf_pkg::S_M4: begin
        if (sts.mul_done) state_nxt = lsf_pkg::S_GD1;
      end
      lsf_pkg::S_GD1: begin
        cmd.div_go = 1'b1;
        cmd.dop    = lsf_pkg::DOP_SLOPE;
        state_nxt  = lsf_pkg::S_D1;
      end
      lsf_pkg::S_D1: begin
        if (sts.div_done) state_nxt = lsf_pkg::S_G5;
      end
      lsf_pkg::S_G5: begin
        cmd.mul_go = 1'b1;
        cmd.mop    = lsf_pkg::MOP_SX_SLOPE;
        state_nxt  = lsf_pkg::S_M5;
      end
      lsf_pkg::S_M5: begin
        if (sts.mul_done) state_nxt = lsf_pkg::S_GD2;
      end
      lsf_pkg::S_GD2: begin
        cmd.div_go = 1'b1;
        cmd.dop    = lsf_pkg::DOP_OFFSET;
        state_nxt  = lsf_pkg::S_D2;
      end
      lsf_pkg::S_D2: begin
        if (sts.div_done) state_nxt = lsf_pkg::S_EMIT;
      end
      lsf_pkg::S_EMIT: begin
        cmd.emit  = 1'b1;
        cmd.kind  = lsf_pkg::EM_FIT;
        state_nxt = lsf_pkg::S_IDLE;
      end
      default: begin
        state_nxt = lsf_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != lsf_pkg::S_IDLE);

endmodule

`default_nettype wire

// File: src/lsf_dp.sv
// ----------------------------------------------------------------------------
// lsf_dp
// Datapath: running sums, shift-add multiplier, restoring divider, results.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic [15:0]                x_sample,
  input  wire logic [15:0]                y_sample,
  input  wire logic                       pair_valid,
  input  wire lsf_pkg::cmd_t              cmd,
  output lsf_pkg::sts_t                   sts,
  output logic                            out_strobe,
  output logic signed [31:0]              out_fit_offset,
  output logic signed [31:0]              out_fit_slope,
  output logic [lsf_pkg::CNT_W-1:0]       out_valid_count,
  output logic [1:0]                      out_fit_status
);

  // running sums
  logic signed [lsf_pkg::AX_W-1:0]  acc_x_r, acc_y_r;
  logic        [lsf_pkg::AXX_W-1:0] acc_xx_r;
  logic signed [lsf_pkg::AXY_W-1:0] acc_xy_r;
  logic        [lsf_pkg::CNT_W-1:0] cnt_r;

  logic signed [15:0] xs, ys;
  logic signed [31:0] xx, xy;
  logic               add_pair;

  assign xs       = 16'($signed(x_sample[lsf_pkg::SAMPLE_BITS-1:0]));
  assign ys       = 16'($signed(y_sample[lsf_pkg::SAMPLE_BITS-1:0]));
  assign xx       = xs * xs;
  assign xy       = xs * ys;
  assign add_pair = accept && pair_valid &&
                    (cnt_r < lsf_pkg::CNT_W'(lsf_pkg::MAX_PAIRS));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      acc_x_r  <= '0;
      acc_y_r  <= '0;
      acc_xx_r <= '0;
      acc_xy_r <= '0;
      cnt_r    <= '0;
    end else if (add_pair) begin
      acc_x_r  <= acc_x_r + lsf_pkg::AX_W'(xs);
      acc_y_r  <= acc_y_r + lsf_pkg::AX_W'(ys);
      acc_xx_r <= acc_xx_r + lsf_pkg::AXX_W'($unsigned(xx));
      acc_xy_r <= acc_xy_r + lsf_pkg::AXY_W'(xy);
      cnt_r    <= cnt_r + 1'b1;
    end
  end

  // magnitudes of the sums
  logic [63:0] sx_m, sy_m, sxy_m, slope_m;
  logic signed [lsf_pkg::PROD_W-1:0] hold_r, den_r, num_r, t_r;
  logic signed [31:0] slope_r, offset_r;
  logic               sat_r;

  assign sx_m    = lsf_pkg::mag64(64'(acc_x_r));
  assign sy_m    = lsf_pkg::mag64(64'(acc_y_r));
  assign sxy_m   = lsf_pkg::mag64(64'(acc_xy_r));
  assign slope_m = lsf_pkg::mag64(64'(slope_r));

  // shift-add multiplier, one multiplier bit per cycle
  logic [lsf_pkg::PROD_W-1:0]    ma_r, mp_r, ma_ld;
  logic [lsf_pkg::MUL_B_W-1:0]   mb_r, mb_ld;
  logic                          mneg_r, mneg_ld, mbusy_r, mfin_r;
  logic [lsf_pkg::MUL_CNT_W-1:0] mcnt_r;
  lsf_pkg::mop_t                 mop_r;
  logic signed [lsf_pkg::PROD_W-1:0] mp_sgn;

  always_comb begin
    ma_ld   = '0;
    mb_ld   = '0;
    mneg_ld = 1'b0;
    case (cmd.mop)
      lsf_pkg::MOP_N_SXX: begin
        ma_ld = 64'(acc_xx_r);
        mb_ld = lsf_pkg::MUL_B_W'(cnt_r);
      end
      lsf_pkg::MOP_SX_SX: begin
        ma_ld = sx_m;
        mb_ld = sx_m[lsf_pkg::MUL_B_W-1:0];
      end
      lsf_pkg::MOP_N_SXY: begin
        ma_ld   = sxy_m;
        mb_ld   = lsf_pkg::MUL_B_W'(cnt_r);
        mneg_ld = acc_xy_r[lsf_pkg::AXY_W-1];
      end
      lsf_pkg::MOP_SX_SY: begin
        ma_ld   = sy_m;
        mb_ld   = sx_m[lsf_pkg::MUL_B_W-1:0];
        mneg_ld = acc_x_r[lsf_pkg::AX_W-1] ^ acc_y_r[lsf_pkg::AX_W-1];
      end
      lsf_pkg::MOP_SX_SLOPE: begin
        ma_ld   = slope_m;
        mb_ld   = sx_m[lsf_pkg::MUL_B_W-1:0];
        mneg_ld = acc_x_r[lsf_pkg::AX_W-1] ^ slope_r[31];
      end
      default: begin
        ma_ld = '0;
      end
    endcase
  end

  assign mp_sgn = mneg_r ? -$signed(mp_r) : $signed(mp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mfin_r  <= 1'b0;
    end else if (cmd.mul_go) begin
      mbusy_r <= 1'b1;
      mfin_r  <= 1'b0;
    end else if (mbusy_r) begin
      mfin_r <= (mcnt_r == lsf_pkg::MUL_CNT_W'(lsf_pkg::MUL_STEPS - 1));
      if (mcnt_r == lsf_pkg::MUL_CNT_W'(lsf_pkg::MUL_STEPS - 1)) mbusy_r <= 1'b0;
    end else begin
      mfin_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      ma_r   <= ma_ld;
      mb_r   <= mb_ld;
      mp_r   <= '0;
      mneg_r <= mneg_ld;
      mop_r  <= cmd.mop;
      mcnt_r <= '0;
    end else if (mbusy_r) begin
      if (mb_r[0]) mp_r <= mp_r + ma_r;
      ma_r   <= {ma_r[lsf_pkg::PROD_W-2:0], 1'b0};
      mb_r   <= {1'b0, mb_r[lsf_pkg::MUL_B_W-1:1]};
      mcnt_r <= mcnt_r + 1'b1;
    end
  end

  // product write-back
  always_ff @(posedge clk) begin
    if (mfin_r) begin
      case (mop_r)
        lsf_pkg::MOP_N_SXX:    hold_r <= mp_sgn;
        lsf_pkg::MOP_SX_SX:    den_r  <= hold_r - mp_sgn;
        lsf_pkg::MOP_N_SXY:    hold_r <= mp_sgn;
        lsf_pkg::MOP_SX_SY:    num_r  <= hold_r - mp_sgn;
        lsf_pkg::MOP_SX_SLOPE:
          t_r <= (64'(acc_y_r) <<< lsf_pkg::FRAC_BITS) - mp_sgn;
        default:               hold_r <= hold_r;
      endcase
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [lsf_pkg::DVD_W-1:0]     dvd_r, dvd_ld, qr;
  logic [63:0]                   dsr_r, dsr_ld, rem_r, rem_step;
  logic [64:0]                   rt;
  logic                          ge, rnd, dneg_r, dneg_ld, dbusy_r, dfin_r, dsat;
  logic [lsf_pkg::DIV_CNT_W-1:0] dcnt_r;
  lsf_pkg::dop_t                 dop_r;
  logic signed [31:0]            dval;

  always_comb begin
    if (cmd.dop == lsf_pkg::DOP_SLOPE) begin
      dvd_ld  = {lsf_pkg::mag64(num_r), {lsf_pkg::FRAC_BITS{1'b0}}};
      dsr_ld  = $unsigned(den_r);
      dneg_ld = num_r[63];
    end else begin
      dvd_ld  = lsf_pkg::DVD_W'(lsf_pkg::mag64(t_r));
      dsr_ld  = 64'(cnt_r) << lsf_pkg::OFS_SHIFT;
      dneg_ld = t_r[63];
    end
  end

  assign rt       = {rem_r, dvd_r[lsf_pkg::DVD_W-1]};
  assign ge       = (rt >= {1'b0, dsr_r});
  assign rem_step = ge ? 64'(rt - {1'b0, dsr_r}) : rt[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dfin_r  <= 1'b0;
    end else if (cmd.div_go) begin
      dbusy_r <= 1'b1;
      dfin_r  <= 1'b0;
    end else if (dbusy_r) begin
      dfin_r <= (dcnt_r == lsf_pkg::DIV_CNT_W'(lsf_pkg::DIV_STEPS - 1));
      if (dcnt_r == lsf_pkg::DIV_CNT_W'(lsf_pkg::DIV_STEPS - 1)) dbusy_r <= 1'b0;
    end else begin
      dfin_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      dvd_r  <= dvd_ld;
      dsr_r  <= dsr_ld;
      rem_r  <= '0;
      dneg_r <= dneg_ld;
      dop_r  <= cmd.dop;
      dcnt_r <= '0;
    end else if (dbusy_r) begin
      dvd_r  <= {dvd_r[lsf_pkg::DVD_W-2:0], ge};
      rem_r  <= rem_step;
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  // round half away from zero, then saturate to 32 bits
  assign rnd  = ({1'b0, rem_r} << 1) >= {1'b0, dsr_r};
  assign qr   = dvd_r + lsf_pkg::DVD_W'(rnd);
  assign dsat = dneg_r ? (qr > lsf_pkg::DVD_W'(64'h8000_0000))
                       : (qr > lsf_pkg::DVD_W'(64'h7FFF_FFFF));
  always_comb begin
    if (dsat) begin
      dval = dneg_r ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      dval = dneg_r ? -$signed(qr[31:0]) : $signed(qr[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (dfin_r) begin
      if (dop_r == lsf_pkg::DOP_SLOPE) begin
        slope_r <= dval;
        sat_r   <= dsat;
      end else begin
        offset_r <= dval;
        sat_r    <= sat_r | dsat;
      end
    end
  end

  // status to the controller
  assign sts.mul_done   = mfin_r;
  assign sts.div_done   = dfin_r;
  assign sts.n_zero     = (cnt_r == '0);
  assign sts.den_nonpos = den_r[63] || (den_r == '0);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_valid_count <= cnt_r;
      case (cmd.kind)
        lsf_pkg::EM_FIT: begin
          out_fit_offset <= offset_r;
          out_fit_slope  <= slope_r;
          out_fit_status <= sat_r ? lsf_pkg::ST_SAT : lsf_pkg::ST_OK;
        end
        lsf_pkg::EM_NONE: begin
          out_fit_offset <= '0;
          out_fit_slope  <= '0;
          out_fit_status <= lsf_pkg::ST_NONE;
        end
        default: begin
          out_fit_offset <= '0;
          out_fit_slope  <= '0;
          out_fit_status <= lsf_pkg::ST_FLAT;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/least_squares_line_fit_top.sv
// ----------------------------------------------------------------------------
// least_squares_line_fit_top
// Least-squares straight-line fit over a stream of Q8.8 sample pairs.
// ----------------------------------------------------------------------------
// A pair is taken when start is high and busy is low; pairs without the
// last mark leave busy low. After a pair with the last mark, busy stays
// high while the fit is computed. For a normal set that is five 48-step
// shift-add products and two 80-step restoring divisions run one after
// another; when no pair was valid or x has no spread it ends after the
// first two products. The result then shows on the out_ ports for one
// cycle with out_strobe high, and the receiver cannot stall it.
`default_nettype none

module least_squares_line_fit_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [15:0]                 in_x_sample,
  input  wire logic [15:0]                 in_y_sample,
  input  wire logic                        in_pair_valid,
  input  wire logic                        in_last_pair,
  output logic                             out_strobe,
  output logic signed [31:0]               out_fit_offset,
  output logic signed [31:0]               out_fit_slope,
  output logic [lsf_pkg::CNT_W-1:0]        out_valid_count,
  output logic [1:0]                       out_fit_status
);

  lsf_pkg::cmd_t cmd;
  lsf_pkg::sts_t sts;
  logic          accept;

  // request handshake
  assign accept = start && !busy;

  lsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .last_pair (in_last_pair),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  lsf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .x_sample        (in_x_sample),
    .y_sample        (in_y_sample),
    .pair_valid      (in_pair_valid),
    .cmd             (cmd),
    .sts             (sts),
    .out_strobe      (out_strobe),
    .out_fit_offset  (out_fit_offset),
    .out_fit_slope   (out_fit_slope),
    .out_valid_count (out_valid_count),
    .out_fit_status  (out_fit_status)
  );

endmodule

`default_nettype wire

// File: src/lsf_chk.sv
// ----------------------------------------------------------------------------
// lsf_chk
// Port-level checks of the line fit block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        in_last_pair,
  input wire logic        out_strobe,
  input wire logic [31:0] out_fit_offset,
  input wire logic [31:0] out_fit_slope,
  input wire logic [16:0] out_valid_count,
  input wire logic [1:0]  out_fit_status
);

  // a plain request keeps the block free
  a_plain_free: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last_pair |=> !busy)
    else $error("busy after a request without last mark");

  // a last request starts the fit
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_pair |=> busy)
    else $error("no fit started after last request");

  // results never come back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("strobe held for two cycles");

  // empty set reports zero pairs
  a_none_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_fit_status == lsf_pkg::ST_NONE) |-> (out_valid_count == '0))
    else $error("empty-set status with nonzero count");

  // degenerate fits give zero line
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && ((out_fit_status == lsf_pkg::ST_NONE) ||
                   (out_fit_status == lsf_pkg::ST_FLAT))
    |-> (out_fit_slope == '0) && (out_fit_offset == '0))
    else $error("degenerate fit with nonzero line");

endmodule

bind least_squares_line_fit_top lsf_chk u_lsf_chk (.*);

`default_nettype wire

// File: dv/least_squares_line_fit_top_tb.sv
// ----------------------------------------------------------------------------
// least_squares_line_fit_top_tb
// Self-checking bench for the least-squares line fit block: sample requests
// are driven with random gaps, each fit is predicted from exact sums and
// compared field by field with what the block emits.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module least_squares_line_fit_top_tb;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        vld;
    logic        lst;
    int          gap;
  } pair_req_t;

  typedef struct {
    logic signed [31:0]        offset;
    logic signed [31:0]        slope;
    logic [lsf_pkg::CNT_W-1:0] count;
    logic [1:0]                status;
  } fit_res_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [15:0] in_x_sample;
  logic [15:0] in_y_sample;
  logic in_pair_valid;
  logic in_last_pair;
  logic out_strobe;
  logic signed [31:0] out_fit_offset;
  logic signed [31:0] out_fit_slope;
  logic [lsf_pkg::CNT_W-1:0] out_valid_count;
  logic [1:0] out_fit_status;

  pair_req_t pending_reqs[$];
  fit_res_t  expected_fits[$];
  int        err_count = 0;
  bit        took_req = 0;

  // running sums of the predicted block
  longint sum_x = 0, sum_y = 0, sum_xx = 0, sum_xy = 0;
  int     pair_cnt = 0;

  least_squares_line_fit_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_x_sample(in_x_sample), .in_y_sample(in_y_sample),
    .in_pair_valid(in_pair_valid), .in_last_pair(in_last_pair),
    .out_strobe(out_strobe), .out_fit_offset(out_fit_offset),
    .out_fit_slope(out_fit_slope), .out_valid_count(out_valid_count),
    .out_fit_status(out_fit_status)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // sign-apply a magnitude and clamp to 32 bits
  function automatic longint clamp32(bit neg, longint unsigned q, inout bit sat);
    if (neg) begin
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        return -64'sh8000_0000;
      end
      return -$signed(q);
    end
    if (q > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 64'sh7FFF_FFFF;
    end
    return $signed(q);
  endfunction

  // fold one pair into the sums; on the last mark queue the expected fit
  task automatic fit_accumulate(input logic [15:0] xs, input logic [15:0] ys,
                                input logic vld, input logic lst);
    longint x, y, n, den, num, slp, ofs, t;
    longint unsigned a, d, q, r;
    logic [1:0] st;
    bit sat;
    fit_res_t res;
    x = longint'($signed(xs));
    y = longint'($signed(ys));
    slp = 0;
    ofs = 0;
    st = lsf_pkg::ST_OK;
    sat = 1'b0;
    if (vld && pair_cnt < lsf_pkg::MAX_PAIRS) begin
      sum_x += x;
      sum_y += y;
      sum_xx += x * x;
      sum_xy += x * y;
      pair_cnt++;
    end
    if (!lst) return;
    n = pair_cnt;
    if (n == 0) begin
      st = lsf_pkg::ST_NONE;
    end else begin
      den = n * sum_xx - sum_x * sum_x;
      if (den <= 0) begin
        st = lsf_pkg::ST_FLAT;
      end else begin
        num = n * sum_xy - sum_x * sum_y;
        a = num < 0 ? -num : num;
        d = den;
        q = a / d;
        r = a % d;
        if (q >= 64'h1_0000) begin
          q = 64'h1_0000_0000;
        end else begin
          for (int i = 0; i < lsf_pkg::FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
              r -= d;
              q |= 1;
            end
          end
          if (r >= d - r) q++;
        end
        slp = clamp32(num < 0, q, sat);
        t = sum_y * 65536 - sum_x * slp;
        a = t < 0 ? -t : t;
        d = n * 256;
        q = a / d;
        r = a % d;
        if (r >= d - r) q++;
        ofs = clamp32(t < 0, q, sat);
        if (sat) st = lsf_pkg::ST_SAT;
      end
    end
    res.offset = ofs[31:0];
    res.slope = slp[31:0];
    res.count = pair_cnt[lsf_pkg::CNT_W-1:0];
    res.status = st;
    expected_fits.push_back(res);
    sum_x = 0;
    sum_y = 0;
    sum_xx = 0;
    sum_xy = 0;
    pair_cnt = 0;
  endtask

  // monitor: check emitted fits, then predict from accepted requests
  always @(posedge clk) begin
    fit_res_t e;
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_fits.size() == 0) begin
          $error("unexpected fit result");
          err_count++;
        end else begin
          e = expected_fits.pop_front();
          if (out_fit_offset !== e.offset) begin
            $error("fit_offset exp %0d got %0d", e.offset, out_fit_offset);
            err_count++;
          end
          if (out_fit_slope !== e.slope) begin
            $error("fit_slope exp %0d got %0d", e.slope, out_fit_slope);
            err_count++;
          end
          if (out_valid_count !== e.count) begin
            $error("valid_count exp %0d got %0d", e.count, out_valid_count);
            err_count++;
          end
          if (out_fit_status !== e.status) begin
            $error("fit_status exp %0d got %0d", e.status, out_fit_status);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        fit_accumulate(in_x_sample, in_y_sample, in_pair_valid, in_last_pair);
      end
    end
    took_req <= rst_n && start && !busy;
  end

  // driver: present queued requests after their gaps
  pair_req_t cur;
  bit        loaded = 0;
  int        gap_left = 0;

  always @(negedge clk) begin
    bit start_nx;
    start_nx = start;
    if (took_req) begin
      start_nx = 1'b0;
      loaded = 0;
    end
    if (rst_n && !start_nx) begin
      if (!loaded && pending_reqs.size() > 0) begin
        cur = pending_reqs.pop_front();
        gap_left = cur.gap;
        loaded = 1;
      end
      if (loaded) begin
        if (gap_left == 0) begin
          start_nx = 1'b1;
          in_x_sample <= cur.x;
          in_y_sample <= cur.y;
          in_pair_valid <= cur.vld;
          in_last_pair <= cur.lst;
        end else begin
          gap_left--;
        end
      end
    end
    start <= start_nx;
  end

  task automatic add_req(input logic [15:0] x, input logic [15:0] y,
                         input logic vld, input logic lst, input int gap);
    pair_req_t p;
    p.x = x;
    p.y = y;
    p.vld = vld;
    p.lst = lst;
    p.gap = gap;
    pending_reqs.push_back(p);
  endtask

  // stimulus
  initial begin
    int n_items, set_len, mode, busy_gaps;
    logic [15:0] xc, xv;
    rst_n = 1'b0;
    start = 1'b0;
    in_x_sample = '0;
    in_y_sample = '0;
    in_pair_valid = 1'b0;
    in_last_pair = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, no valid pairs, single pair, flat x, saturation
    add_req(16'h8000, 16'h7FFF, 1, 0, 0);
    add_req(16'h7FFF, 16'h8000, 1, 0, 3);
    add_req(16'h0000, 16'hFFFF, 1, 0, 0);
    add_req(16'hFFFF, 16'h0000, 1, 1, 0);
    add_req(16'h1234, 16'h5678, 0, 0, 2);
    add_req(16'h1234, 16'h5678, 0, 1, 0);
    add_req(16'h0100, 16'h0200, 1, 1, 1);
    add_req(16'h0300, 16'h0100, 1, 0, 0);
    add_req(16'h0300, 16'hF000, 1, 0, 0);
    add_req(16'h0300, 16'h7000, 1, 1, 0);
    add_req(16'h0000, 16'h8000, 1, 0, 0);
    add_req(16'h0001, 16'h7FFF, 1, 1, 0);
    add_req(16'h0000, 16'h7FFF, 1, 0, 0);
    add_req(16'h0001, 16'h8000, 1, 1, 0);
    add_req(16'h8000, 16'h8000, 1, 0, 0);
    add_req(16'h7FFF, 16'h7FFF, 1, 0, 0);
    add_req(16'h0000, 16'h0000, 0, 0, 0);
    add_req(16'h0010, 16'h0020, 1, 1, 5);
    add_req(16'h0000, 16'h0000, 1, 0, 0);
    add_req(16'h0001, 16'h0001, 1, 0, 0);
    add_req(16'h0002, 16'h0002, 1, 1, 0);

    // random sets, mostly well-formed with random content
    n_items = 0;
    while (n_items < 1500) begin
      mode = $urandom_range(0, 9);
      set_len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 200)
                                               : $urandom_range(1, 24);
      busy_gaps = $urandom_range(0, 3) != 0;
      xc = 16'($urandom);
      for (int i = 0; i < set_len; i++) begin
        case (mode)
          0: xv = xc;
          1: xv = 16'($signed(16'($urandom_range(0, 15))) - 8);
          2: xv = ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
          default: xv = 16'($urandom);
        endcase
        add_req(xv, (mode == 2) ? 16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)
                                : 16'($urandom),
                (mode == 3) ? 1'b0 : ($urandom_range(0, 9) != 0),
                i == set_len - 1,
                busy_gaps ? $urandom_range(0, 11) : 0);
      end
      n_items += set_len;
    end

    wait (pending_reqs.size() == 0 && !loaded);
    while (expected_fits.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (err_count == 0 && expected_fits.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: least_squares_line_fit_top.f
src/lsf_pkg.sv
src/lsf_ctrl.sv
src/lsf_dp.sv
src/least_squares_line_fit_top.sv
src/lsf_chk.sv
dv/least_squares_line_fit_top_tb.sv
